[rtl/kcdc_pkg.sv]
package kcdc_pkg;

    localparam int ENTRY_DEPTH_DEF = 20;
    localparam int CODE_CHARS      = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int TIMER_W         = 16;
    localparam int CODE_IDX_W      = 3;

    // command kinds
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_KEY  = 2'd1;
    localparam logic [1:0] CMD_LINK = 2'd2;

    // door phases
    localparam logic [1:0] PH_CLOSED  = 2'd0;
    localparam logic [1:0] PH_OPENING = 2'd1;
    localparam logic [1:0] PH_OPEN    = 2'd2;
    localparam logic [1:0] PH_CLOSING = 2'd3;

    // entry phases
    localparam logic [1:0] EN_MENU  = 2'd0;
    localparam logic [1:0] EN_ENTER = 2'd1;
    localparam logic [1:0] EN_AWAIT = 2'd2;
    localparam logic [1:0] EN_LOCK  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_WORD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_OPEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_IDLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_WAIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WRONG    = 3'd7;

    // register reset values
    localparam logic [63:0]        CODE_WORD_RST    = 64'd875770417;
    localparam logic [3:0]         CODE_LENGTH_RST  = 4'd4;
    localparam logic [TIMER_W-1:0] TRAVEL_LIMIT_RST = 16'd15000;
    localparam logic [TIMER_W-1:0] HOLD_OPEN_RST    = 16'd5000;
    localparam logic [TIMER_W-1:0] ENTRY_IDLE_RST   = 16'd3000;
    localparam logic [TIMER_W-1:0] FACE_WAIT_RST    = 16'd20000;
    localparam logic [TIMER_W-1:0] LOCKOUT_RST      = 16'd2000;
    localparam logic [3:0]         MAX_WRONG_RST    = 4'd3;

    localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;
    localparam logic [9:0]         DUTY_FULL = 10'd999;

    // characters
    localparam logic [7:0] KEY_NONE = 8'h00;
    localparam logic [7:0] KEY_ONE  = 8'h31;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] LINK_O   = 8'h4F;
    localparam logic [7:0] LINK_X   = 8'h58;
    localparam logic [7:0] LINK_P   = 8'h50;
    localparam logic [7:0] SEND_L   = 8'h4C;
    localparam logic [7:0] SEND_U   = 8'h55;
    localparam logic [7:0] SEND_F   = 8'h46;
    localparam logic [7:0] SEND_A   = 8'h41;
    localparam logic [7:0] SEND_NONE = 8'h00;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] key_code;
        logic [7:0] link_byte;
        logic       open_limit;
        logic       close_limit;
        logic       person_seen;
    } kcdc_in_t;

    typedef struct packed {
        logic [9:0] motor_duty;
        logic       drive_open;
        logic       drive_close;
        logic       lamp_on;
        logic       buzzer_on;
        logic       send_valid;
        logic [7:0] send_byte;
        logic [1:0] door_phase_now;
        logic [1:0] entry_phase_now;
        logic [4:0] entry_length;
    } kcdc_out_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic walk_init;
        logic walk_rd;
        logic walk_next;
        logic set_match;
        logic apply;
    } kcdc_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic needs_walk;
        logic byte_eq;
        logic walk_last;
        logic out_free;
    } kcdc_sts_t;

    function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] v);
        return (v == TIMER_MAX) ? v : v + 16'd1;
    endfunction

endpackage

[rtl/kcdc_ctrl.sv]
module kcdc_ctrl
    import kcdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  kcdc_sts_t sts,
    output kcdc_ctl_t ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.walk_init = 1'b1;
                state_next    = sts.needs_walk ? S_RD : S_APPLY;
            end
            S_RD:
            begin
                ctl.walk_rd = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (!sts.byte_eq)
                begin
                    state_next = S_APPLY;
                end
                else if (sts.walk_last)
                begin
                    ctl.set_match = 1'b1;
                    state_next    = S_APPLY;
                end
                else
                begin
                    ctl.walk_next = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_APPLY:
            begin
                if (sts.out_free)
                begin
                    ctl.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/kcdc_datapath.sv]
module kcdc_datapath
    import kcdc_pkg::*;
#(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kcdc_in_t              item,
    input  logic                  result_ready,
    output logic                  result_valid,
    output kcdc_out_t             result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  kcdc_ctl_t             ctl,
    output kcdc_sts_t             sts
);

    localparam int AW   = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CW   = $clog2(ENTRY_DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    // configuration registers
    logic [63:0]        code_word_reg;
    logic [3:0]         code_length_reg;
    logic [TIMER_W-1:0] travel_limit_reg;
    logic [TIMER_W-1:0] hold_open_reg;
    logic [TIMER_W-1:0] entry_idle_reg;
    logic [TIMER_W-1:0] face_wait_reg;
    logic [TIMER_W-1:0] lockout_reg;
    logic [3:0]         max_wrong_reg;

    // block state
    logic [1:0]         door_phase_reg,   door_phase_next;
    logic [TIMER_W-1:0] door_elapsed_reg, door_elapsed_next;
    logic [1:0]         entry_phase_reg,  entry_phase_next;
    logic [TIMER_W-1:0] idle_elapsed_reg, idle_elapsed_next;
    logic [TIMER_W-1:0] wait_elapsed_reg, wait_elapsed_next;
    logic [CW-1:0]      entry_count_reg,  entry_count_next;
    logic [3:0]         wrong_count_reg,  wrong_count_next;
    logic               lamp_reg,         lamp_next;

    logic [7:0]         entry_mem [ENTRY_DEPTH];
    logic               mem_we;

    kcdc_in_t           item_reg;
    kcdc_out_t          result_reg, result_next;
    logic               result_valid_reg;

    logic [CODE_IDX_W-1:0] walk_idx_reg;
    logic                  match_reg;
    logic [7:0]            rd_data_reg;

    logic [3:0]         code_len_eff;
    logic [TIMER_W-1:0] door_bump;
    logic [TIMER_W-1:0] door_hold;
    logic [TIMER_W-1:0] idle_bump;
    logic [TIMER_W-1:0] wait_bump;
    logic [3:0]         wrong_sum;
    logic               send_valid;
    logic [7:0]         send_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_word_reg    <= CODE_WORD_RST;
            code_length_reg  <= CODE_LENGTH_RST;
            travel_limit_reg <= TRAVEL_LIMIT_RST;
            hold_open_reg    <= HOLD_OPEN_RST;
            entry_idle_reg   <= ENTRY_IDLE_RST;
            face_wait_reg    <= FACE_WAIT_RST;
            lockout_reg      <= LOCKOUT_RST;
            max_wrong_reg    <= MAX_WRONG_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CODE_WORD:    code_word_reg    <= cfg_data;
                REG_CODE_LENGTH:  code_length_reg  <= cfg_data[3:0];
                REG_TRAVEL_LIMIT: travel_limit_reg <= cfg_data[TIMER_W-1:0];
                REG_HOLD_OPEN:    hold_open_reg    <= cfg_data[TIMER_W-1:0];
                REG_ENTRY_IDLE:   entry_idle_reg   <= cfg_data[TIMER_W-1:0];
                REG_FACE_WAIT:    face_wait_reg    <= cfg_data[TIMER_W-1:0];
                REG_LOCKOUT:      lockout_reg      <= cfg_data[TIMER_W-1:0];
                REG_MAX_WRONG:    max_wrong_reg    <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (code_length_reg == 4'd0)
        begin
            code_len_eff = 4'd1;
        end
        else if (code_length_reg > 4'(CODE_CHARS))
        begin
            code_len_eff = 4'(CODE_CHARS);
        end
        else
        begin
            code_len_eff = code_length_reg;
        end
    end

    // item register, entry memory write and compare walk read
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg <= item;
        end
        if (ctl.walk_rd)
        begin
            rd_data_reg <= entry_mem[AW'(walk_idx_reg)];
        end
        if (mem_we)
        begin
            entry_mem[entry_count_reg[AW-1:0]] <= item_reg.key_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_idx_reg <= '0;
            match_reg    <= 1'b0;
        end
        else if (ctl.walk_init)
        begin
            walk_idx_reg <= '0;
            match_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.walk_next)
            begin
                walk_idx_reg <= walk_idx_reg + 3'd1;
            end
            if (ctl.set_match)
            begin
                match_reg <= 1'b1;
            end
        end
    end

    assign sts.needs_walk = (item_reg.cmd == CMD_KEY) && (item_reg.key_code == KEY_HASH)
                            && (entry_phase_reg == EN_ENTER)
                            && (CMPW'(entry_count_reg) == CMPW'(code_len_eff));
    assign sts.byte_eq    = rd_data_reg == code_word_reg[{walk_idx_reg, 3'b000} +: 8];
    assign sts.walk_last  = (4'(walk_idx_reg) + 4'd1) == code_len_eff;
    assign sts.out_free   = !result_valid_reg || result_ready;

    assign door_bump = bump(door_elapsed_reg);
    assign door_hold = item_reg.person_seen ? '0 : door_bump;
    assign idle_bump = bump(idle_elapsed_reg);
    assign wait_bump = bump(wait_elapsed_reg);
    assign wrong_sum = wrong_count_reg + 4'd1;

    always_comb
    begin
        door_phase_next   = door_phase_reg;
        door_elapsed_next = door_elapsed_reg;
        entry_phase_next  = entry_phase_reg;
        idle_elapsed_next = idle_elapsed_reg;
        wait_elapsed_next = wait_elapsed_reg;
        entry_count_next  = entry_count_reg;
        wrong_count_next  = wrong_count_reg;
        lamp_next         = lamp_reg;
        send_valid        = 1'b0;
        send_byte         = SEND_NONE;
        mem_we            = 1'b0;
        case (item_reg.cmd)
            CMD_TICK:
            begin
                case (door_phase_reg)
                    PH_OPENING:
                    begin
                        door_elapsed_next = door_bump;
                        if (item_reg.open_limit || door_bump > travel_limit_reg)
                        begin
                            door_phase_next   = PH_OPEN;
                            door_elapsed_next = '0;
                        end
                    end
                    PH_OPEN:
                    begin
                        door_elapsed_next = door_hold;
                        if (door_hold > hold_open_reg)
                        begin
                            door_phase_next   = PH_CLOSING;
                            door_elapsed_next = '0;
                        end
                    end
                    PH_CLOSING:
                    begin
                        if (item_reg.person_seen)
                        begin
                            door_phase_next   = PH_OPENING;
                            door_elapsed_next = '0;
                        end
                        else
                        begin
                            door_elapsed_next = door_bump;
                            if (item_reg.close_limit || door_bump > travel_limit_reg)
                            begin
                                door_phase_next   = PH_CLOSED;
                                door_elapsed_next = '0;
                                lamp_next         = 1'b0;
                                send_valid        = 1'b1;
                                send_byte         = SEND_L;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                case (entry_phase_reg)
                    EN_ENTER:
                    begin
                        idle_elapsed_next = idle_bump;
                        if (idle_bump > entry_idle_reg)
                        begin
                            entry_phase_next = EN_MENU;
                            entry_count_next = '0;
                        end
                    end
                    EN_AWAIT:
                    begin
                        wait_elapsed_next = wait_bump;
                        if (wait_bump >= face_wait_reg)
                        begin
                            entry_phase_next = EN_MENU;
                        end
                    end
                    EN_LOCK:
                    begin
                        wait_elapsed_next = wait_bump;
                        if (wait_bump >= lockout_reg)
                        begin
                            entry_phase_next  = EN_ENTER;
                            entry_count_next  = '0;
                            idle_elapsed_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_KEY:
            begin
                if (item_reg.key_code != KEY_NONE
                    && (entry_phase_reg == EN_MENU || entry_phase_reg == EN_ENTER))
                begin
                    idle_elapsed_next = '0;
                    if (entry_phase_reg == EN_MENU)
                    begin
                        if (item_reg.key_code == KEY_ONE)
                        begin
                            entry_phase_next = EN_ENTER;
                            entry_count_next = '0;
                        end
                    end
                    else if (item_reg.key_code == KEY_HASH)
                    begin
                        entry_count_next = '0;
                        if (match_reg)
                        begin
                            wrong_count_next  = '0;
                            entry_phase_next  = EN_AWAIT;
                            wait_elapsed_next = '0;
                            send_valid        = 1'b1;
                            send_byte         = SEND_F;
                        end
                        else if (wrong_sum >= max_wrong_reg)
                        begin
                            wrong_count_next  = '0;
                            entry_phase_next  = EN_LOCK;
                            wait_elapsed_next = '0;
                        end
                        else
                        begin
                            wrong_count_next = wrong_sum;
                        end
                    end
                    else if (item_reg.key_code == KEY_STAR)
                    begin
                        if (entry_count_reg != '0)
                        begin
                            entry_count_next = entry_count_reg - CW'(1);
                        end
                    end
                    else if (entry_count_reg < CW'(ENTRY_DEPTH))
                    begin
                        mem_we           = ctl.apply;
                        entry_count_next = entry_count_reg + CW'(1);
                    end
                end
            end
            CMD_LINK:
            begin
                if (entry_phase_reg != EN_LOCK)
                begin
                    if (item_reg.link_byte == LINK_O)
                    begin
                        entry_phase_next  = EN_MENU;
                        entry_count_next  = '0;
                        lamp_next         = 1'b1;
                        door_phase_next   = PH_OPENING;
                        door_elapsed_next = '0;
                        send_valid        = 1'b1;
                        send_byte         = SEND_U;
                    end
                    else if (entry_phase_reg == EN_AWAIT)
                    begin
                        if (item_reg.link_byte == LINK_X)
                        begin
                            entry_phase_next = EN_MENU;
                        end
                    end
                    else if (item_reg.link_byte == LINK_P)
                    begin
                        send_valid = 1'b1;
                        send_byte  = SEND_A;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result_next                 = '0;
        result_next.motor_duty      = (door_phase_next == PH_OPENING
                                       || door_phase_next == PH_CLOSING) ? DUTY_FULL : 10'd0;
        result_next.drive_open      = door_phase_next == PH_OPENING;
        result_next.drive_close     = door_phase_next == PH_CLOSING;
        result_next.lamp_on         = lamp_next;
        result_next.buzzer_on       = entry_phase_next == EN_LOCK;
        result_next.send_valid      = send_valid;
        result_next.send_byte       = send_byte;
        result_next.door_phase_now  = door_phase_next;
        result_next.entry_phase_now = entry_phase_next;
        result_next.entry_length    = 5'(entry_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_phase_reg   <= PH_CLOSED;
            door_elapsed_reg <= '0;
            entry_phase_reg  <= EN_MENU;
            idle_elapsed_reg <= '0;
            wait_elapsed_reg <= '0;
            entry_count_reg  <= '0;
            wrong_count_reg  <= '0;
            lamp_reg         <= 1'b0;
        end
        else if (ctl.apply)
        begin
            door_phase_reg   <= door_phase_next;
            door_elapsed_reg <= door_elapsed_next;
            entry_phase_reg  <= entry_phase_next;
            idle_elapsed_reg <= idle_elapsed_next;
            wait_elapsed_reg <= wait_elapsed_next;
            entry_count_reg  <= entry_count_next;
            wrong_count_reg  <= wrong_count_next;
            lamp_reg         <= lamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctl.apply)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.apply)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/keypad_code_door_controller_core.sv]
// door controller with keypad code entry
// item channel: item_valid/item_ready carry one tick, key press or link byte
// with the limit switch and presence levels; one result per item comes back
// on result_valid/result_ready with motor drive, lamp, buzzer, link status
// byte, the phases and the entry length after the item
// a result is registered once its transfer passes the decode and update steps,
// and a new item transfers only once the last one is through load, decode and update;
// a '#' key whose entry length equals the code length adds a read and a compare
// step per code character walked, through the single read port of the entry
// character memory
// the result sits in an output register, so the next item transfers while
// it waits; a stalled receiver holds the following item in its update step
// configuration: cfg_write with cfg_index and cfg_data; the user must write
// only while the block is idle, which the block itself does not enforce
// reset: door closed, entry at menu, lamp off, timers and counters cleared,
// registers at their defaults; entry characters are not cleared
module keypad_code_door_controller_core
    import kcdc_pkg::*;
#(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  kcdc_in_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output kcdc_out_t             result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    kcdc_ctl_t ctl;
    kcdc_sts_t sts;

    kcdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    kcdc_datapath #(
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .sts          (sts)
    );

endmodule

[tb/keypad_code_door_controller_core_test.sv]
module keypad_code_door_controller_core_test;

    import kcdc_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    kcdc_in_t              item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    kcdc_out_t             result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register mirror
    logic [63:0] code_word_reg;
    logic [3:0]  code_len_reg;
    logic [15:0] travel_ms;
    logic [15:0] hold_ms;
    logic [15:0] idle_limit;
    logic [15:0] face_limit;
    logic [15:0] lock_limit;
    logic [3:0]  max_wrong_reg;

    // controller state mirror
    logic [1:0]  door_ph;
    logic [15:0] door_ms;
    logic [1:0]  entry_ph;
    logic [15:0] idle_ms;
    logic [15:0] wait_ms;
    int          typed_cnt;
    logic [7:0]  typed [ENTRY_DEPTH_DEF];
    logic [3:0]  miss_cnt;
    logic        lamp_lit;

    kcdc_in_t  pending_events [$];
    kcdc_out_t expected_status [$];
    int        queued_count = 0;
    int        status_count = 0;
    int        fail_count = 0;
    int        send_gap = 0;
    int        hold_left = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    keypad_code_door_controller_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return v + {15'd0, ~&v};
    endfunction

    function automatic int code_chars_used();
        if (code_len_reg == 4'd0)
            return 1;
        if (code_len_reg > CODE_CHARS)
            return CODE_CHARS;
        return code_len_reg;
    endfunction

    function automatic kcdc_out_t predict_status(input kcdc_in_t it);
        kcdc_out_t  r;
        logic       sent;
        logic [7:0] sent_byte;
        int         want_len;
        logic       hit;
        sent = 1'b0;
        sent_byte = SEND_NONE;
        case (it.cmd)
            CMD_TICK:
            begin
                case (door_ph)
                    PH_OPENING:
                    begin
                        door_ms = sat_inc(door_ms);
                        if (it.open_limit || door_ms > travel_ms)
                        begin
                            door_ph = PH_OPEN;
                            door_ms = '0;
                        end
                    end
                    PH_OPEN:
                    begin
                        door_ms = it.person_seen ? 16'd0 : sat_inc(door_ms);
                        if (door_ms > hold_ms)
                        begin
                            door_ph = PH_CLOSING;
                            door_ms = '0;
                        end
                    end
                    PH_CLOSING:
                    begin
                        if (it.person_seen)
                        begin
                            door_ph = PH_OPENING;
                            door_ms = '0;
                        end
                        else
                        begin
                            door_ms = sat_inc(door_ms);
                            if (it.close_limit || door_ms > travel_ms)
                            begin
                                door_ph = PH_CLOSED;
                                door_ms = '0;
                                lamp_lit = 1'b0;
                                sent = 1'b1;
                                sent_byte = SEND_L;
                            end
                        end
                    end
                    default: ;
                endcase
                case (entry_ph)
                    EN_ENTER:
                    begin
                        idle_ms = sat_inc(idle_ms);
                        if (idle_ms > idle_limit)
                        begin
                            entry_ph = EN_MENU;
                            typed_cnt = 0;
                        end
                    end
                    EN_AWAIT:
                    begin
                        wait_ms = sat_inc(wait_ms);
                        if (wait_ms >= face_limit)
                            entry_ph = EN_MENU;
                    end
                    EN_LOCK:
                    begin
                        wait_ms = sat_inc(wait_ms);
                        if (wait_ms >= lock_limit)
                        begin
                            entry_ph = EN_ENTER;
                            typed_cnt = 0;
                            idle_ms = '0;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_KEY:
            begin
                if (it.key_code != KEY_NONE && (entry_ph == EN_MENU || entry_ph == EN_ENTER))
                begin
                    idle_ms = '0;
                    if (entry_ph == EN_MENU)
                    begin
                        if (it.key_code == KEY_ONE)
                        begin
                            entry_ph = EN_ENTER;
                            typed_cnt = 0;
                        end
                    end
                    else if (it.key_code == KEY_HASH)
                    begin
                        want_len = code_chars_used();
                        hit = (typed_cnt == want_len);
                        for (int i = 0; i < CODE_CHARS; i++)
                        begin
                            if (hit && i < want_len && typed[i] != code_word_reg[8*i +: 8])
                                hit = 1'b0;
                        end
                        typed_cnt = 0;
                        if (hit)
                        begin
                            miss_cnt = '0;
                            entry_ph = EN_AWAIT;
                            wait_ms = '0;
                            sent = 1'b1;
                            sent_byte = SEND_F;
                        end
                        else
                        begin
                            miss_cnt = miss_cnt + 4'd1;
                            if (miss_cnt >= max_wrong_reg)
                            begin
                                miss_cnt = '0;
                                entry_ph = EN_LOCK;
                                wait_ms = '0;
                            end
                        end
                    end
                    else if (it.key_code == KEY_STAR)
                    begin
                        if (typed_cnt > 0)
                            typed_cnt--;
                    end
                    else if (typed_cnt < ENTRY_DEPTH_DEF)
                    begin
                        typed[typed_cnt] = it.key_code;
                        typed_cnt++;
                    end
                end
            end
            CMD_LINK:
            begin
                if (entry_ph != EN_LOCK)
                begin
                    if (it.link_byte == LINK_O)
                    begin
                        entry_ph = EN_MENU;
                        typed_cnt = 0;
                        lamp_lit = 1'b1;
                        door_ph = PH_OPENING;
                        door_ms = '0;
                        sent = 1'b1;
                        sent_byte = SEND_U;
                    end
                    else if (entry_ph == EN_AWAIT)
                    begin
                        if (it.link_byte == LINK_X)
                            entry_ph = EN_MENU;
                    end
                    else if (it.link_byte == LINK_P)
                    begin
                        sent = 1'b1;
                        sent_byte = SEND_A;
                    end
                end
            end
            default: ;
        endcase
        r.motor_duty = (door_ph == PH_OPENING || door_ph == PH_CLOSING) ? DUTY_FULL : 10'd0;
        r.drive_open = (door_ph == PH_OPENING);
        r.drive_close = (door_ph == PH_CLOSING);
        r.lamp_on = lamp_lit;
        r.buzzer_on = (entry_ph == EN_LOCK);
        r.send_valid = sent;
        r.send_byte = sent_byte;
        r.door_phase_now = door_ph;
        r.entry_phase_now = entry_ph;
        r.entry_length = 5'(typed_cnt);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic push_event(input logic [1:0] c, input logic [7:0] k, input logic [7:0] b,
                              input logic [2:0] lv);
        kcdc_in_t e;
        e.cmd = c;
        e.key_code = k;
        e.link_byte = b;
        {e.open_limit, e.close_limit, e.person_seen} = lv;
        pending_events.push_back(e);
        queued_count++;
    endtask

    function automatic logic [2:0] rand_levels();
        return {$urandom_range(3) == 0, $urandom_range(3) == 0, $urandom_range(3) == 0};
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(9));
    endfunction

    task automatic push_key(input logic [7:0] k);
        push_event(CMD_KEY, k, 8'($urandom), rand_levels());
    endtask

    task automatic push_link(input logic [7:0] b);
        push_event(CMD_LINK, 8'($urandom), b, rand_levels());
    endtask

    task automatic push_tick();
        push_event(CMD_TICK, 8'($urandom), 8'($urandom), rand_levels());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_CODE_WORD:    code_word_reg = val;
            REG_CODE_LENGTH:  code_len_reg = val[3:0];
            REG_TRAVEL_LIMIT: travel_ms = val[15:0];
            REG_HOLD_OPEN:    hold_ms = val[15:0];
            REG_ENTRY_IDLE:   idle_limit = val[15:0];
            REG_FACE_WAIT:    face_limit = val[15:0];
            REG_LOCKOUT:      lock_limit = val[15:0];
            REG_MAX_WRONG:    max_wrong_reg = val[3:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [63:0] code, input logic [3:0] len,
                                  input logic [15:0] travel, input logic [15:0] hold,
                                  input logic [15:0] idle, input logic [15:0] face,
                                  input logic [15:0] lock, input logic [3:0] wrong);
        write_reg(REG_CODE_WORD, code);
        write_reg(REG_CODE_LENGTH, 64'(len));
        write_reg(REG_TRAVEL_LIMIT, 64'(travel));
        write_reg(REG_HOLD_OPEN, 64'(hold));
        write_reg(REG_ENTRY_IDLE, 64'(idle));
        write_reg(REG_FACE_WAIT, 64'(face));
        write_reg(REG_LOCKOUT, 64'(lock));
        write_reg(REG_MAX_WRONG, 64'(wrong));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [63:0] rand_code_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) : rand_digit();
        return w;
    endfunction

    task automatic settle();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || item_valid || expected_status.size() != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic queue_random_events(input int n);
        int stop_at;
        int pick;
        int want_len;
        int tries;
        logic right;
        stop_at = queued_count + n;
        while (queued_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                repeat ($urandom_range(8, 1)) push_tick();
            end
            else if (pick < 60)
            begin
                right = (pick < 50);
                want_len = right ? code_chars_used() : $urandom_range(9);
                push_key(KEY_ONE);
                for (int i = 0; i < want_len; i++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        push_key(rand_digit());
                        push_key(KEY_STAR);
                    end
                    if ($urandom_range(7) == 0)
                        push_tick();
                    push_key(right ? code_word_reg[8*i +: 8] : rand_digit());
                end
                push_key(KEY_HASH);
                if (right)
                begin
                    repeat ($urandom_range(2)) push_tick();
                    pick = $urandom_range(9);
                    push_link(pick < 5 ? LINK_O : (pick < 8 ? LINK_X : 8'($urandom)));
                end
            end
            else if (pick < 70)
            begin
                tries = (max_wrong_reg > 6) ? 6 : max_wrong_reg;
                push_key(KEY_ONE);
                repeat (tries) push_key(KEY_HASH);
                push_key(KEY_ONE);
                push_link(LINK_O);
                tries = (lock_limit > 12) ? 14 : lock_limit + 2;
                repeat ($urandom_range(tries, 1)) push_tick();
            end
            else if (pick < 80)
            begin
                pick = $urandom_range(3);
                push_link(pick == 0 ? LINK_O : (pick == 1 ? LINK_X :
                          (pick == 2 ? LINK_P : 8'($urandom))));
            end
            else if (pick < 90)
            begin
                pick = $urandom_range(4);
                push_key(pick == 0 ? KEY_NONE : (pick == 1 ? KEY_ONE :
                         (pick == 2 ? KEY_HASH : (pick == 3 ? KEY_STAR : 8'($urandom)))));
            end
            else if (pick < 92)
            begin
                push_key(KEY_ONE);
                repeat ($urandom_range(ENTRY_DEPTH_DEF + 3, ENTRY_DEPTH_DEF - 1))
                    push_key(8'($urandom_range(255, 1)));
                push_key(KEY_STAR);
                push_key(KEY_HASH);
            end
            else
            begin
                push_event(2'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
                push_event(CMD_NONE, 8'($urandom), 8'($urandom), 3'($urandom));
            end
        end
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_gap = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                expected_status.push_back(predict_status(item));
                if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                    send_gap = $urandom_range(16, 1);
            end
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    item <= pending_events.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // status monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                status_count++;
                if (expected_status.size() == 0)
                begin
                    $error("status transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    kcdc_out_t want;
                    want = expected_status.pop_front();
                    check_field("motor_duty", want.motor_duty, result.motor_duty);
                    check_field("drive_open", want.drive_open, result.drive_open);
                    check_field("drive_close", want.drive_close, result.drive_close);
                    check_field("lamp_on", want.lamp_on, result.lamp_on);
                    check_field("buzzer_on", want.buzzer_on, result.buzzer_on);
                    check_field("send_valid", want.send_valid, result.send_valid);
                    check_field("send_byte", want.send_byte, result.send_byte);
                    check_field("door_phase_now", want.door_phase_now, result.door_phase_now);
                    check_field("entry_phase_now", want.entry_phase_now, result.entry_phase_now);
                    check_field("entry_length", want.entry_length, result.entry_length);
                end
                // long back-pressure so the block fills up
                if (status_count == 120 || status_count == 330)
                    hold_left = 200;
            end
            if (hold_left == 0 && stall_pct != 0 && $urandom_range(99) < stall_pct)
                hold_left = $urandom_range(16, 1);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        #6000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        code_word_reg = CODE_WORD_RST;
        code_len_reg = CODE_LENGTH_RST;
        travel_ms = TRAVEL_LIMIT_RST;
        hold_ms = HOLD_OPEN_RST;
        idle_limit = ENTRY_IDLE_RST;
        face_limit = FACE_WAIT_RST;
        lock_limit = LOCKOUT_RST;
        max_wrong_reg = MAX_WRONG_RST;
        door_ph = PH_CLOSED;
        door_ms = '0;
        entry_ph = EN_MENU;
        idle_ms = '0;
        wait_ms = '0;
        typed_cnt = 0;
        miss_cnt = '0;
        lamp_lit = 1'b0;
        foreach (typed[i])
            typed[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 30;
        stall_pct = 5;

        push_event(CMD_TICK, 8'($urandom), 8'($urandom), 3'b000);
        push_key(KEY_NONE);
        push_key("2");
        push_key(KEY_ONE);
        push_key(KEY_ONE);
        push_key("2");
        push_key("3");
        push_key("5");
        push_key(KEY_STAR);
        push_key("4");
        push_key(KEY_HASH);
        push_link(LINK_P);
        push_link(LINK_O);
        push_event(CMD_TICK, 8'($urandom), 8'($urandom), 3'b100);
        push_event(CMD_TICK, 8'($urandom), 8'($urandom), 3'b001);
        push_link(LINK_P);
        push_event(CMD_NONE, 8'($urandom), 8'($urandom), 3'($urandom));
        push_key(KEY_ONE);
        push_key(KEY_HASH);
        push_key(KEY_HASH);
        push_key(KEY_HASH);
        push_key(KEY_ONE);
        push_link(LINK_O);
        push_link(LINK_X);
        settle();

        apply_settings(rand_code_word(), 4'($urandom_range(8, 1)), 16'd6, 16'd3, 16'd8,
                       16'd6, 16'd5, 4'd2);
        queue_random_events(150);
        settle();

        idle_pct = 0;
        stall_pct = 0;
        apply_settings(64'd0, 4'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 4'd1);
        queue_random_events(80);
        settle();

        idle_pct = 40;
        stall_pct = 8;
        apply_settings({64{1'b1}}, 4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       4'd15);
        queue_random_events(80);
        settle();

        idle_pct = 25;
        stall_pct = 5;
        apply_settings(rand_code_word(), 4'($urandom_range(8, 1)), 16'($urandom_range(12, 2)),
                       16'($urandom_range(12, 2)), 16'($urandom_range(12, 2)),
                       16'($urandom_range(12, 2)), 16'($urandom_range(12, 2)),
                       4'($urandom_range(4, 1)));
        queue_random_events(130);
        settle();

        idle_pct = 0;
        stall_pct = 0;
        apply_settings(rand_code_word(), 4'($urandom_range(8, 1)), 16'($urandom_range(12, 2)),
                       16'($urandom_range(12, 2)), 16'($urandom_range(12, 2)),
                       16'($urandom_range(12, 2)), 16'($urandom_range(12, 2)),
                       4'($urandom_range(4, 1)));
        queue_random_events(90);
        settle();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
